>>> hdl/hcd_pkg.sv
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types, codes and helpers for the HTTP chunked transfer decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcd_pkg;

    localparam int SIZE_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 32;

    localparam int CAP_W    = 32;
    localparam int REPORT_W = 32;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;

    localparam logic [4:0] HEX_NONE = 5'd16;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_HDR   = 3'd1,
        PH_PAY   = 3'd2,
        PH_TCR   = 3'd3,
        PH_TLF   = 3'd4,
        PH_FCR   = 3'd5,
        PH_FLF   = 3'd6,
        PH_STOP  = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_CLEAN      = 2'd0,
        ST_FINAL      = 2'd1,
        ST_INCOMPLETE = 2'd2,
        ST_INVALID    = 2'd3
    } t_status;

    typedef struct packed {
        logic digit;
        logic fault;
        logic ext;
        logic cr;
        logic over;
    } t_flags;

    typedef struct packed {
        logic [REPORT_W-1:0] out_count;
        logic [REPORT_W-1:0] in_count;
        t_status             status;
        logic [7:0]          payload_byte;
        logic                kind;
    } t_result;

    // Returns the value of an ASCII hex digit, or HEX_NONE for anything else.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        begin
            v = HEX_NONE;
            if (b >= 8'h30 && b <= 8'h39) begin
                v = 5'(b - 8'h30);
            end else if (b >= 8'h61 && b <= 8'h66) begin
                v = 5'(b - 8'h57);
            end else if (b >= 8'h41 && b <= 8'h46) begin
                v = 5'(b - 8'h37);
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/http_chunked_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_decoder
// Streaming decoder for HTTP chunked transfer coding, one byte per transfer.
// ----------------------------------------------------------------------------
// The decoder accepts one input transfer per clock while s_axis_tready is high,
// and produces at most one result per input: a payload byte, or a summary at
// the end-of-buffer marker. Each input is fully handled by the parser in the
// cycle it is accepted, and its result is registered in the output stage. The
// output stage is a register with one skid entry; s_axis_tready drops only while
// that entry is occupied, so the sustained rate is one byte per clock whenever
// the sink keeps up. There is no clearing pass after reset. The capacity register
// may be written only while the decoder is idle.
`default_nettype none

module http_chunked_decoder #(
    parameter int SIZE_BITS  = hcd_pkg::SIZE_BITS_DEF,
    parameter int COUNT_BITS = hcd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [hcd_pkg::CAP_W-1:0]  i_cfg_data,    // payload capacity
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [7:0]                 s_axis_tdata,  // [7:0] byte_value
    input  wire logic                       s_axis_tuser,  // [0] op
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // [7:0] payload_byte, [9:8] status, [41:10] in_count,
    // [73:42] out_count, [79:74] zero
    output logic [79:0]                     m_axis_tdata,
    output logic                            m_axis_tuser   // [0] kind
);
    import hcd_pkg::*;

    logic    in_accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    hcd_core #(
        .SIZE_BITS  (SIZE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (in_accept),
        .i_op       (s_axis_tuser),
        .i_byte     (s_axis_tdata),
        .o_valid    (res_valid),
        .o_result   (res)
    );

    hcd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (out_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, out_res.out_count, out_res.in_count,
                           out_res.status, out_res.payload_byte};
    assign m_axis_tuser = out_res.kind;

endmodule

`default_nettype wire

>>> hdl/hcd_core.sv
// ----------------------------------------------------------------------------
// hcd_core
// Chunk parser: header, payload and trailer tracking with committed counts.
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_core #(
    parameter int SIZE_BITS  = hcd_pkg::SIZE_BITS_DEF,
    parameter int COUNT_BITS = hcd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [hcd_pkg::CAP_W-1:0]  i_cfg_data,
    input  wire logic                       i_valid,
    input  wire logic                       i_op,
    input  wire logic [7:0]                 i_byte,
    output logic                            o_valid,
    output hcd_pkg::t_result                o_result
);
    import hcd_pkg::*;

    localparam int SUM_W = ((COUNT_BITS > SIZE_BITS) ? COUNT_BITS : SIZE_BITS) + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [CAP_W-1:0]      r_capacity;
    t_phase                r_phase,    n_phase;
    logic [SIZE_BITS-1:0]  r_chunk_len, n_chunk_len;
    logic [SIZE_BITS-1:0]  r_left,     n_left;
    logic [COUNT_BITS-1:0] r_position, n_position;
    logic [COUNT_BITS-1:0] r_consumed, n_consumed;
    logic [COUNT_BITS-1:0] r_decoded,  n_decoded;
    t_flags                r_flags,    n_flags;
    t_status               r_stop,     n_stop;

    logic                  step;
    logic                  end_item;
    logic [COUNT_BITS-1:0] pos_inc;
    logic [SIZE_BITS-1:0]  h_len;
    t_flags                h_fl;
    logic                  h_done;
    logic [4:0]            digit;
    logic [SIZE_BITS-1:0]  sum_len;
    logic [SUM_W-1:0]      sum;
    logic                  fits;
    logic [COUNT_BITS-1:0] sat_sum;
    logic                  tlf_bad;
    t_status               end_status;
    logic [COUNT_BITS+REPORT_W-1:0] consumed_ext;
    logic [COUNT_BITS+REPORT_W-1:0] decoded_ext;

    assign step     = i_valid && (i_op == OP_BYTE) && (r_phase != PH_STOP);
    assign end_item = i_valid && (i_op == OP_END);
    assign pos_inc  = (&r_position) ? r_position : r_position + 1'b1;
    assign digit    = hex_value(i_byte);
    assign tlf_bad  = r_flags.over || r_flags.fault || (i_byte != CH_LF);

    // One header character. A header start drops what the last chunk left behind.
    always_comb begin
        h_len  = (r_phase == PH_START) ? '0 : r_chunk_len;
        h_fl   = (r_phase == PH_START) ? '0 : r_flags;
        h_done = 1'b0;
        if (h_fl.cr) begin
            h_fl.cr = 1'b0;
            if (i_byte == CH_LF) begin
                h_done = 1'b1;
            end else if (!h_fl.ext) begin
                h_fl.fault = 1'b1;
            end
        end
        if (!h_done) begin
            if (i_byte == CH_CR) begin
                h_fl.cr = 1'b1;
            end else if (!(h_fl.fault || h_fl.ext)) begin
                if (i_byte == CH_SEMI || i_byte == CH_SP || i_byte == CH_TAB) begin
                    h_fl.ext = 1'b1;
                end else if (digit == HEX_NONE || h_len[SIZE_BITS-1 -: 4] != 4'd0) begin
                    // A nonzero top nibble means one more digit would overflow.
                    h_fl.fault = 1'b1;
                end else begin
                    h_len      = {h_len[SIZE_BITS-5:0], digit[3:0]};
                    h_fl.digit = 1'b1;
                end
            end
        end
    end

    // One adder serves the capacity check and the commit of decoded bytes.
    assign sum_len = (r_phase == PH_TLF) ? r_chunk_len : h_len;
    assign sum     = SUM_W'(r_decoded) + SUM_W'(sum_len);
    assign fits    = (sum <= SUM_W'(r_capacity));
    assign sat_sum = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : sum[COUNT_BITS-1:0];

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (end_item) begin
            n_phase = PH_START;
        end else if (step) begin
            unique case (r_phase)
                PH_START, PH_HDR: begin
                    if (!h_done) begin
                        n_phase = PH_HDR;
                    end else if (h_fl.fault || !h_fl.digit) begin
                        n_phase = PH_STOP;
                    end else if (h_len == '0) begin
                        n_phase = PH_FCR;
                    end else begin
                        n_phase = PH_PAY;
                    end
                end
                PH_PAY:  n_phase = (r_left == SIZE_BITS'(1)) ? PH_TCR : PH_PAY;
                PH_TCR:  n_phase = PH_TLF;
                PH_TLF:  n_phase = tlf_bad ? PH_STOP : PH_START;
                PH_FCR:  n_phase = (i_byte == CH_CR) ? PH_FLF : PH_STOP;
                PH_FLF:  n_phase = PH_STOP;
                default: n_phase = PH_STOP;
            endcase
        end
    end

    // Datapath registers.
    always_comb begin
        n_chunk_len = r_chunk_len;
        n_left      = r_left;
        n_position  = r_position;
        n_consumed  = r_consumed;
        n_decoded   = r_decoded;
        n_flags     = r_flags;
        n_stop      = r_stop;
        if (end_item) begin
            n_chunk_len = '0;
            n_left      = '0;
            n_position  = '0;
            n_consumed  = '0;
            n_decoded   = '0;
            n_flags     = '0;
            n_stop      = ST_CLEAN;
        end else if (step) begin
            n_position = pos_inc;
            case (r_phase)
                PH_START, PH_HDR: begin
                    n_chunk_len = h_len;
                    n_flags     = h_fl;
                    if (h_done) begin
                        if (h_fl.fault || !h_fl.digit) begin
                            n_stop = ST_INVALID;
                        end else if (h_len == '0) begin
                            n_consumed = pos_inc;
                            n_stop     = ST_FINAL;
                        end else begin
                            n_flags      = '0;
                            n_flags.over = !fits;
                            n_left       = h_len;
                        end
                    end
                end
                PH_PAY: n_left = r_left - 1'b1;
                PH_TCR: begin
                    if (i_byte != CH_CR) begin
                        n_flags.fault = 1'b1;
                    end
                end
                PH_TLF: begin
                    if (tlf_bad) begin
                        n_flags.fault = r_flags.fault || (i_byte != CH_LF);
                        n_stop        = ST_INVALID;
                    end else begin
                        n_decoded   = sat_sum;
                        n_consumed  = pos_inc;
                        n_flags     = '0;
                        n_chunk_len = '0;
                    end
                end
                PH_FLF: begin
                    if (i_byte == CH_LF) begin
                        n_consumed = pos_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_phase == PH_STOP || r_phase == PH_FCR || r_phase == PH_FLF) begin
            end_status = r_stop;
        end else if (r_phase == PH_START) begin
            end_status = ST_CLEAN;
        end else begin
            end_status = ST_INCOMPLETE;
        end
    end

    assign consumed_ext = {{REPORT_W{1'b0}}, r_consumed};
    assign decoded_ext  = {{REPORT_W{1'b0}}, r_decoded};

    // Result toward the output stage.
    always_comb begin
        o_valid  = 1'b0;
        o_result = '0;
        if (end_item) begin
            o_valid            = 1'b1;
            o_result.kind      = KIND_SUMMARY;
            o_result.status    = end_status;
            o_result.in_count  = consumed_ext[REPORT_W-1:0];
            o_result.out_count = decoded_ext[REPORT_W-1:0];
        end else if (step && r_phase == PH_PAY && !r_flags.over) begin
            o_valid               = 1'b1;
            o_result.kind         = KIND_PAYLOAD;
            o_result.payload_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= {CAP_W{1'b1}};
            r_phase     <= PH_START;
            r_chunk_len <= '0;
            r_left      <= '0;
            r_position  <= '0;
            r_consumed  <= '0;
            r_decoded   <= '0;
            r_flags     <= '0;
            r_stop      <= ST_CLEAN;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            r_phase     <= n_phase;
            r_chunk_len <= n_chunk_len;
            r_left      <= n_left;
            r_position  <= n_position;
            r_consumed  <= n_consumed;
            r_decoded   <= n_decoded;
            r_flags     <= n_flags;
            r_stop      <= n_stop;
        end
    end

`ifndef ASSERT_OFF
    a_pay_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY) |-> (r_left != '0))
        else $error("payload phase with no bytes left");

    a_final_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FCR || r_phase == PH_FLF) |-> (r_stop == ST_FINAL))
        else $error("final trailer phase without final status");

    a_commit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_consumed <= r_position)
        else $error("committed count ahead of position");
`endif

endmodule

`default_nettype wire

>>> hdl/hcd_skid.sv
// ----------------------------------------------------------------------------
// hcd_skid
// Output register with one skid entry, so the input-side ready never depends
// combinationally on the output-side ready.
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_skid (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  hcd_pkg::t_result      i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output hcd_pkg::t_result      o_data,
    input  wire logic             i_ready
);
    import hcd_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_take;

    assign out_take = r_out_valid && i_ready;
    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_valid) begin
                // New results only arrive while the skid entry is free.
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            if (!r_out_valid || out_take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end else if (out_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid entry lost or changed while stalled");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !r_skid_valid)
        else $error("result arrived with the skid entry full");
`endif

endmodule

`default_nettype wire

>>> bench/http_chunked_decoder_test.sv
// ----------------------------------------------------------------------------
// http_chunked_decoder_test
// Self-checking bench for the chunked transfer decoder: a short table of
// directed buffers, then random buffers (mostly well-formed chunk streams,
// some corrupted or truncated, some noise) under several capacity settings,
// with random valid gaps, random sink stalls and one long sink hold.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hcd_pkg::*;

    localparam int          RANDOM_ITEMS = 700;
    localparam int          CAP_PHASES   = 6;
    localparam logic [63:0] COUNT_MAX    = 64'hFFFF_FFFF;
    localparam logic [63:0] SIZE_CEIL    = (64'hFFFF_FFFF - 64'd15) / 64'd16;

    typedef struct {
        logic    op;
        logic [7:0] value;
        bit      pinned;
        t_result want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tuser;

    http_chunked_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("** http_chunked_decoder: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Decoder model state
    // ------------------------------------------------------------------
    logic [31:0] capacity;
    t_phase      dec_phase;
    logic [63:0] dec_len;
    logic [63:0] dec_left;
    logic [63:0] dec_pos;
    logic [63:0] dec_consumed;
    logic [63:0] dec_decoded;
    logic        fl_digit, fl_fault, fl_ext, fl_cr, fl_over;
    t_status     dec_stop;

    t_result     expected_q[$];
    t_row        stim_q[$];
    t_row        cur_row;
    int          useful_items;
    int          mismatches;
    int          src_burst;

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] x;
        x = (a > COUNT_MAX) ? COUNT_MAX : a;
        return (b > COUNT_MAX - x) ? COUNT_MAX : x + b;
    endfunction

    function automatic int nibble_of(input logic [7:0] b);
        int v;
        v = 16;
        if (b >= "0" && b <= "9") v = int'(b) - int'("0");
        if (b >= "a" && b <= "f") v = int'(b) - int'("a") + 10;
        if (b >= "A" && b <= "F") v = int'(b) - int'("A") + 10;
        return v;
    endfunction

    function automatic void clear_buffer();
        dec_phase    = PH_START;
        dec_len      = '0;
        dec_left     = '0;
        dec_pos      = '0;
        dec_consumed = '0;
        dec_decoded  = '0;
        {fl_digit, fl_fault, fl_ext, fl_cr, fl_over} = '0;
        dec_stop     = ST_CLEAN;
    endfunction

    function automatic void go_invalid();
        dec_stop  = ST_INVALID;
        dec_phase = PH_STOP;
    endfunction

    function automatic void close_header();
        logic [63:0] cap;
        cap = {32'd0, capacity};
        if (fl_fault || !fl_digit) begin
            go_invalid();
            return;
        end
        if (dec_len == 0) begin
            dec_consumed = dec_pos;
            dec_stop     = ST_FINAL;
            dec_phase    = PH_FCR;
            return;
        end
        {fl_digit, fl_fault, fl_ext, fl_cr} = '0;
        fl_over   = !(dec_decoded <= cap && dec_len <= cap - dec_decoded);
        dec_left  = dec_len;
        dec_phase = PH_PAY;
    endfunction

    function automatic void header_char(input logic [7:0] b);
        int h;
        dec_phase = PH_HDR;
        if (fl_cr) begin
            fl_cr = 1'b0;
            if (b == CH_LF) begin
                close_header();
                return;
            end
            // A CR that is not followed by LF counts as a bad size character, unless an extension has begun.
            if (!fl_ext) fl_fault = 1'b1;
        end
        if (b == CH_CR) begin
            fl_cr = 1'b1;
            return;
        end
        if (fl_fault || fl_ext) return;
        if (b == CH_SEMI || b == CH_SP || b == CH_TAB) begin
            fl_ext = 1'b1;
            return;
        end
        h = nibble_of(b);
        if (h > 15 || dec_len > SIZE_CEIL) begin
            fl_fault = 1'b1;
            return;
        end
        dec_len  = dec_len * 16 + 64'(h);
        fl_digit = 1'b1;
    endfunction

    // Advances the model by one input transfer; returns 1 when it yields a result.
    function automatic bit decode_step(input logic op, input logic [7:0] b,
                                       output t_result res);
        bit produced;
        res = '0;
        produced = 1'b0;
        if (op == OP_END) begin
            res.kind = KIND_SUMMARY;
            if (dec_phase == PH_STOP || dec_phase == PH_FCR || dec_phase == PH_FLF) begin
                res.status = dec_stop;
            end else if (dec_phase == PH_START) begin
                res.status = ST_CLEAN;
            end else begin
                res.status = ST_INCOMPLETE;
            end
            res.in_count  = dec_consumed[31:0];
            res.out_count = dec_decoded[31:0];
            clear_buffer();
            return 1'b1;
        end
        if (dec_phase == PH_STOP) return 1'b0;
        dec_pos = sat_sum(dec_pos, 64'd1);
        case (dec_phase)
            PH_START: begin
                dec_len = '0;
                {fl_digit, fl_fault, fl_ext, fl_cr, fl_over} = '0;
                header_char(b);
            end
            PH_HDR: begin
                header_char(b);
            end
            PH_PAY: begin
                if (!fl_over) begin
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = b;
                    produced         = 1'b1;
                end
                dec_left = dec_left - 1;
                if (dec_left == 0) dec_phase = PH_TCR;
            end
            PH_TCR: begin
                if (b != CH_CR) fl_fault = 1'b1;
                dec_phase = PH_TLF;
            end
            PH_TLF: begin
                if (b != CH_LF) fl_fault = 1'b1;
                if (fl_over || fl_fault) begin
                    go_invalid();
                end else begin
                    dec_decoded  = sat_sum(dec_decoded, dec_len);
                    dec_consumed = dec_pos;
                    {fl_digit, fl_fault, fl_ext, fl_cr, fl_over} = '0;
                    dec_len      = '0;
                    dec_phase    = PH_START;
                end
            end
            PH_FCR: begin
                if (b == CH_CR) begin
                    dec_phase = PH_FLF;
                end else begin
                    dec_phase = PH_STOP;
                end
            end
            PH_FLF: begin
                if (b == CH_LF) dec_consumed = dec_pos;
                dec_phase = PH_STOP;
            end
            default: begin
                dec_phase = PH_STOP;
            end
        endcase
        return produced;
    endfunction

    // ------------------------------------------------------------------
    // Input and output monitor
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input t_result want,
                                   input t_result got);
        if (mismatches < 10) begin
            $display("%t %s: expected kind=%0d byte=%02h status=%0d consumed=%0d decoded=%0d",
                     $realtime, what, want.kind, want.payload_byte, want.status,
                     want.in_count, want.out_count);
            $display("%t %s:      got kind=%0d byte=%02h status=%0d consumed=%0d decoded=%0d",
                     $realtime, what, got.kind, got.payload_byte, got.status,
                     got.in_count, got.out_count);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result model_res;
        bit      has_res;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind         = m_axis_tuser;
                got.payload_byte = m_axis_tdata[7:0];
                got.status       = t_status'(m_axis_tdata[9:8]);
                got.in_count     = m_axis_tdata[41:10];
                got.out_count    = m_axis_tdata[73:42];
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                        got.status !== want.status ||
                        got.in_count !== want.in_count ||
                        got.out_count !== want.out_count) begin
                        report_mismatch("result mismatch", want, got);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (!(cur_row.op == OP_BYTE && dec_phase == PH_STOP)) useful_items++;
                has_res = decode_step(cur_row.op, cur_row.value, model_res);
                if (cur_row.pinned) begin
                    expected_q.push_back(cur_row.want);
                end else if (has_res) begin
                    expected_q.push_back(model_res);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink: random stalls, stall-free stretches and one long hold
    // ------------------------------------------------------------------
    initial begin : sink
        int stall_left;
        int run_left;
        int pick;
        bit held;
        stall_left = 0;
        run_left   = 0;
        held       = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && useful_items >= 250) begin
                // Hold off long enough for the output stage to fill and stall the input.
                held       = 1'b1;
                stall_left = 300;
                run_left   = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_axis_tready <= 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    run_left = $urandom_range(20, 60);
                    m_axis_tready <= 1'b1;
                end else if (pick < 65) begin
                    m_axis_tready <= 1'b1;
                end else if (pick < 94) begin
                    stall_left = $urandom_range(0, 2);
                    m_axis_tready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(8, 40);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_result summary_of(input t_status st, input logic [31:0] consumed,
                                           input logic [31:0] decoded);
        t_result r;
        r = '0;
        r.kind      = KIND_SUMMARY;
        r.status    = st;
        r.in_count  = consumed;
        r.out_count = decoded;
        return r;
    endfunction

    function automatic t_result payload_of(input logic [7:0] b);
        t_result r;
        r = '0;
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        return r;
    endfunction

    task automatic add_row(input logic op, input logic [7:0] v, input bit pinned = 1'b0,
                           input t_result want = '0);
        t_row row;
        row.op     = op;
        row.value  = v;
        row.pinned = pinned;
        row.want   = want;
        stim_q.push_back(row);
    endtask

    task automatic push_size(input logic [31:0] v);
        int n;
        int nib;
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 2)) add_row(OP_BYTE, "0");
        end
        n = 1;
        while (n < 8 && (v >> (4 * n)) != 0) n++;
        for (int i = n - 1; i >= 0; i--) begin
            nib = int'(v[4 * i +: 4]);
            if (nib < 10) begin
                add_row(OP_BYTE, 8'(int'("0") + nib));
            end else if ($urandom_range(0, 1) == 1) begin
                add_row(OP_BYTE, 8'(int'("a") + nib - 10));
            end else begin
                add_row(OP_BYTE, 8'(int'("A") + nib - 10));
            end
        end
    endtask

    task automatic push_header_end();
        int pick;
        if ($urandom_range(0, 4) == 0) begin
            pick = $urandom_range(0, 2);
            if (pick == 0) add_row(OP_BYTE, CH_SEMI);
            else if (pick == 1) add_row(OP_BYTE, CH_SP);
            else add_row(OP_BYTE, CH_TAB);
            repeat ($urandom_range(0, 4)) add_row(OP_BYTE, 8'($urandom_range(8'h21, 8'h7E)));
        end
        add_row(OP_BYTE, CH_CR);
        add_row(OP_BYTE, CH_LF);
    endtask

    // Queues one random buffer, closed by an end marker.
    task automatic gen_buffer();
        int pick;
        int start;
        int len;
        int cut;
        pick  = $urandom_range(0, 99);
        start = stim_q.size();
        if (pick < 12) begin
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 3))
                    0: add_row(OP_BYTE, 8'($urandom_range(0, 255)));
                    1: add_row(OP_BYTE, "7");
                    2: add_row(OP_BYTE, CH_CR);
                    default: add_row(OP_BYTE, CH_LF);
                endcase
            end
        end else if (pick < 16) begin
            if ($urandom_range(0, 1) == 1) begin
                // Nine digits overflow the size field.
                add_row(OP_BYTE, "1");
                repeat (8) add_row(OP_BYTE, "0");
                push_header_end();
            end else begin
                // Largest size that fits; the buffer ends long before the payload does.
                repeat (8) add_row(OP_BYTE, "F");
                push_header_end();
                repeat ($urandom_range(0, 6)) add_row(OP_BYTE, 8'($urandom_range(0, 255)));
            end
        end else begin
            repeat ($urandom_range(0, 4)) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 12);
                push_size(32'(len));
                push_header_end();
                repeat (len) add_row(OP_BYTE, 8'($urandom_range(0, 255)));
                add_row(OP_BYTE, CH_CR);
                add_row(OP_BYTE, CH_LF);
            end
            if ($urandom_range(0, 9) < 7) begin
                push_size(32'd0);
                push_header_end();
                case ($urandom_range(0, 3))
                    1: begin
                        add_row(OP_BYTE, CH_CR);
                        add_row(OP_BYTE, CH_LF);
                    end
                    2: add_row(OP_BYTE, CH_CR);
                    3: begin
                        add_row(OP_BYTE, CH_CR);
                        add_row(OP_BYTE, 8'($urandom_range(0, 255)));
                    end
                    default: ;
                endcase
                repeat ($urandom_range(0, 2)) add_row(OP_BYTE, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 3) == 0 && stim_q.size() > start) begin
                cut = $urandom_range(start, stim_q.size() - 1);
                if ($urandom_range(0, 1) == 1) begin
                    stim_q[cut].value = 8'($urandom_range(0, 255));
                end else begin
                    while (stim_q.size() > cut) void'(stim_q.pop_back());
                end
            end
        end
        add_row(OP_END, 8'($urandom_range(0, 255)));
    endtask

    // Presents one row after a random gap and waits until it is accepted.
    task automatic send_row(input t_row row);
        int gap;
        int pick;
        if (src_burst > 0) begin
            src_burst--;
            gap = 0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3) src_burst = $urandom_range(20, 60);
            if (pick < 60) gap = 0;
            else if (pick < 92) gap = $urandom_range(1, 3);
            else gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.value;
        s_axis_tuser  <= row.op;
        cur_row       <= row;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_queued();
        while (stim_q.size() != 0) send_row(stim_q.pop_front());
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        capacity    = value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          base;
        logic [31:0] caps[CAP_PHASES];
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_BYTE;
        cur_row       = '{OP_BYTE, 8'h00, 1'b0, '0};
        useful_items  = 0;
        mismatches    = 0;
        src_burst     = 0;
        capacity      = 32'hFFFF_FFFF;
        clear_buffer();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty buffer right after reset.
        add_row(OP_END, 8'hA5, 1'b1, summary_of(ST_CLEAN, 0, 0));
        // Two extreme payload bytes, then the final chunk and its CRLF.
        add_row(OP_BYTE, "2");
        add_row(OP_BYTE, CH_CR);
        add_row(OP_BYTE, CH_LF);
        add_row(OP_BYTE, 8'h00, 1'b1, payload_of(8'h00));
        add_row(OP_BYTE, 8'hFF, 1'b1, payload_of(8'hFF));
        add_row(OP_BYTE, CH_CR);
        add_row(OP_BYTE, CH_LF);
        add_row(OP_BYTE, "0");
        add_row(OP_BYTE, CH_CR);
        add_row(OP_BYTE, CH_LF);
        add_row(OP_BYTE, CH_CR);
        add_row(OP_BYTE, CH_LF);
        add_row(OP_END, 8'h5A, 1'b1, summary_of(ST_FINAL, 12, 2));
        // A bad size character makes the header invalid at its CRLF.
        add_row(OP_BYTE, "g");
        add_row(OP_BYTE, CH_CR);
        add_row(OP_BYTE, CH_LF);
        add_row(OP_END, 8'h00, 1'b1, summary_of(ST_INVALID, 0, 0));
        // Buffer ends inside a header.
        add_row(OP_BYTE, "5");
        add_row(OP_BYTE, CH_CR);
        add_row(OP_END, 8'hFF, 1'b1, summary_of(ST_INCOMPLETE, 0, 0));
        // Bytes after the stop are ignored.
        add_row(OP_BYTE, "0");
        add_row(OP_BYTE, CH_CR);
        add_row(OP_BYTE, CH_LF);
        add_row(OP_BYTE, "X");
        add_row(OP_BYTE, "Y");
        add_row(OP_END, 8'h3C, 1'b1, summary_of(ST_FINAL, 3, 0));
        send_queued();

        caps[0] = 32'hFFFF_FFFF;
        caps[1] = 32'd0;
        caps[2] = 32'($urandom_range(1, 40));
        caps[3] = $urandom;
        caps[4] = 32'd64;
        caps[5] = 32'hFFFF_FFFF;
        base = useful_items;
        for (int ph = 0; ph < CAP_PHASES; ph++) begin
            drain();
            write_capacity(caps[ph]);
            while (useful_items < base + (ph + 1) * RANDOM_ITEMS / CAP_PHASES) begin
                gen_buffer();
                send_queued();
            end
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("** http_chunked_decoder: PASSED **");
        end else begin
            $display("** http_chunked_decoder: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
